// ----- src/u8e_pkg.sv -----
// Shared types, constants and helpers for the extended UTF-8 encoder.
package u8e_pkg;

    // Upper bound of each length class (inclusive)
    localparam logic [31:0] LIMIT_1B = 32'h0000_007F;
    localparam logic [31:0] LIMIT_2B = 32'h0000_07FF;
    localparam logic [31:0] LIMIT_3B = 32'h0000_FFFF;
    localparam logic [31:0] LIMIT_4B = 32'h001F_FFFF;
    localparam logic [31:0] LIMIT_5B = 32'h03FF_FFFF;
    localparam logic [31:0] LIMIT_6B = 32'h7FFF_FFFF;

    // Lead markers by sequence length
    localparam logic [7:0] LEAD_2B = 8'hC0;
    localparam logic [7:0] LEAD_3B = 8'hE0;
    localparam logic [7:0] LEAD_4B = 8'hF0;
    localparam logic [7:0] LEAD_5B = 8'hF8;
    localparam logic [7:0] LEAD_6B = 8'hFC;
    localparam logic [7:0] LEAD_7B = 8'hFE;

    // Continuation byte framing
    localparam logic [7:0] CONT_MARK = 8'h80;
    localparam int unsigned CONT_BITS = 6;

    // Six continuation groups of six bits at most
    localparam int unsigned PAY_W = 36;
    localparam int unsigned CONT_CNT_W = 3;

    // One classified character between front and back
    typedef struct packed {
        logic [7:0]            lead;
        logic [PAY_W-1:0]      pay;
        logic [CONT_CNT_W-1:0] conts;
    } u8e_entry_t;

    // Lead marker for a given number of continuation bytes
    function automatic logic [7:0] lead_mark(input logic [CONT_CNT_W-1:0] conts);
        logic [7:0] mark;
        case (conts)
            3'd1:    mark = LEAD_2B;
            3'd2:    mark = LEAD_3B;
            3'd3:    mark = LEAD_4B;
            3'd4:    mark = LEAD_5B;
            3'd5:    mark = LEAD_6B;
            3'd6:    mark = LEAD_7B;
            default: mark = 8'h00;
        endcase
        return mark;
    endfunction

endpackage

// ----- src/u8e_front.sv -----
// Front end: takes a code point, picks its length class, builds the lead byte
// and left-aligns the continuation payload.
module u8e_front
    import u8e_pkg::*;
(
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [31:0] s_code_point,
    output logic        push_valid,
    input  logic        push_ready,
    output u8e_entry_t  push_entry
);

    logic [CONT_CNT_W-1:0] conts;
    logic [7:0]            lead_bits;
    logic [PAY_W-1:0]      pay;

    // Length class by value range
    always_comb begin
        if (s_code_point <= LIMIT_1B) begin
            conts = 3'd0;
        end else if (s_code_point <= LIMIT_2B) begin
            conts = 3'd1;
        end else if (s_code_point <= LIMIT_3B) begin
            conts = 3'd2;
        end else if (s_code_point <= LIMIT_4B) begin
            conts = 3'd3;
        end else if (s_code_point <= LIMIT_5B) begin
            conts = 3'd4;
        end else if (s_code_point <= LIMIT_6B) begin
            conts = 3'd5;
        end else begin
            conts = 3'd6;
        end
    end

    // Bits above the continuation groups, and the groups themselves, MSB first
    always_comb begin
        case (conts)
            3'd0: begin
                lead_bits = s_code_point[7:0];
                pay       = '0;
            end
            3'd1: begin
                lead_bits = s_code_point[13:6];
                pay       = {s_code_point[5:0], 30'd0};
            end
            3'd2: begin
                lead_bits = s_code_point[19:12];
                pay       = {s_code_point[11:0], 24'd0};
            end
            3'd3: begin
                lead_bits = s_code_point[25:18];
                pay       = {s_code_point[17:0], 18'd0};
            end
            3'd4: begin
                lead_bits = s_code_point[31:24];
                pay       = {s_code_point[23:0], 12'd0};
            end
            3'd5: begin
                lead_bits = {6'd0, s_code_point[31:30]};
                pay       = {s_code_point[29:0], 6'd0};
            end
            default: begin
                lead_bits = 8'h00;
                pay       = {4'd0, s_code_point};
            end
        endcase
    end

    assign push_entry.lead  = lead_mark(conts) | lead_bits;
    assign push_entry.pay   = pay;
    assign push_entry.conts = conts;

    assign push_valid = s_valid;
    assign s_ready    = push_ready;

endmodule

// ----- src/u8e_queue.sv -----
// Two-entry queue that decouples classification from byte serialization.
module u8e_queue
    import u8e_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       in_valid,
    output logic       in_ready,
    input  u8e_entry_t in_entry,
    output logic       out_valid,
    input  logic       out_ready,
    output u8e_entry_t out_entry
);

    u8e_entry_t entry_reg [2];
    logic [1:0] count_reg, count_next;
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic       push, pop;

    assign in_ready  = (count_reg != 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign out_entry = entry_reg[rd_ptr_reg];

    assign push = in_valid && in_ready;
    assign pop  = out_valid && out_ready;

    // Pointer and fill bookkeeping
    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg  <= 2'd0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end else begin
            count_reg  <= count_next;
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
        end
    end

    // Payload storage
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= in_entry;
        end
    end

endmodule

// ----- src/u8e_back.sv -----
// Back end: serializes one queued character into bytes through an output register.
module u8e_back
    import u8e_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        pop_valid,
    output logic        pop_ready,
    input  u8e_entry_t  pop_entry,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_byte_value,
    output logic        m_last_byte
);

    logic                  m_valid_reg, m_valid_next;
    logic [7:0]            byte_reg, byte_next;
    logic                  last_reg, last_next;
    logic [PAY_W-1:0]      pay_reg, pay_next;
    logic [CONT_CNT_W-1:0] rem_reg, rem_next;
    logic                  advance;

    // Output slot is free or its byte leaves this cycle
    assign advance   = !m_valid_reg || m_ready;
    assign pop_ready = advance && (rem_reg == '0);

    // Next byte: pending continuation first, else the next lead byte
    always_comb begin
        m_valid_next = m_valid_reg;
        byte_next    = byte_reg;
        last_next    = last_reg;
        pay_next     = pay_reg;
        rem_next     = rem_reg;
        if (advance) begin
            if (rem_reg != '0) begin
                m_valid_next = 1'b1;
                byte_next    = CONT_MARK | {2'b00, pay_reg[PAY_W-1 -: CONT_BITS]};
                last_next    = (rem_reg == 3'd1);
                pay_next     = pay_reg << CONT_BITS;
                rem_next     = rem_reg - 3'd1;
            end else if (pop_valid) begin
                m_valid_next = 1'b1;
                byte_next    = pop_entry.lead;
                last_next    = (pop_entry.conts == '0);
                pay_next     = pop_entry.pay;
                rem_next     = pop_entry.conts;
            end else begin
                m_valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            rem_reg     <= '0;
        end else begin
            m_valid_reg <= m_valid_next;
            rem_reg     <= rem_next;
        end
    end

    always_ff @(posedge aclk) begin
        byte_reg <= byte_next;
        last_reg <= last_next;
        pay_reg  <= pay_next;
    end

    assign m_valid      = m_valid_reg;
    assign m_byte_value = byte_reg;
    assign m_last_byte  = last_reg;

endmodule

// ----- src/utf8_extended_encoder.sv -----
// Top level of the extended UTF-8 encoder.
//
// Input channel (s_valid/s_ready): one 32-bit code point per transfer.
// Output channel (m_valid/m_ready): one encoded byte per transfer, lead byte
// first, m_last_byte high on the final byte of each character.
// Sequence length is 1 to 7 bytes: up to 0x7F one byte, up to 0x7FFFFFFF the
// 2- to 6-byte forms, and values with bit 31 set the 7-byte form (lead 0xFE).
// When the block is empty, the lead byte is written into the queue at the input
// transfer and then into the output register, from which it drives m_*.
// Throughput: one byte per cycle while m_ready is high; a character has 1 to 7
// bytes, and the byte serializer in the back end sets this rate.
// A two-entry queue between classifier and serializer keeps s_ready high while
// it has a free entry, so a following code point is taken while the serializer works.
// Reset (aresetn low, synchronous) empties the queue and the output register.
// When the receiver holds m_ready low the current byte is held unchanged;
// the queue fills and then s_ready drops until bytes move again.
module utf8_extended_encoder
    import u8e_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [31:0] s_code_point,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_byte_value,
    output logic        m_last_byte
);

    logic       push_valid, push_ready;
    u8e_entry_t push_entry;
    logic       pop_valid, pop_ready;
    u8e_entry_t pop_entry;

    // Classification
    u8e_front u_front (
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_code_point (s_code_point),
        .push_valid   (push_valid),
        .push_ready   (push_ready),
        .push_entry   (push_entry)
    );

    // Decoupling queue
    u8e_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (push_valid),
        .in_ready  (push_ready),
        .in_entry  (push_entry),
        .out_valid (pop_valid),
        .out_ready (pop_ready),
        .out_entry (pop_entry)
    );

    // Byte serialization
    u8e_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .pop_valid    (pop_valid),
        .pop_ready    (pop_ready),
        .pop_entry    (pop_entry),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_byte_value (m_byte_value),
        .m_last_byte  (m_last_byte)
    );

endmodule
